// File: hw/rtl/dotq_pkg.sv
// ----------------------------------------------------------------------------
// dotq_pkg: shared types and constants for the deadline ordered timer queue
// Holds field widths, queue depth and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package dotq_pkg;

    localparam int Capacity = 16;
    localparam int IdxW     = $clog2(Capacity);
    localparam int TimeW    = 48;
    localparam int DelayW   = 32;
    localparam int LisW     = 8;
    localparam int TokW     = 32;

    // input tdata: now_ms, delay_ms, listener_id, event_token = 120 bits
    localparam int InW  = TimeW + DelayW + LisW + TokW;
    localparam int InDW = ((InW + 7) / 8) * 8;
    // output tdata: fired_listener, fired_token, fired_deadline = 88 bits
    localparam int ResW  = LisW + TokW + TimeW;
    // result word with status in bit 0
    localparam int OutW  = 1 + ResW;
    localparam int OutDW = ((ResW + 7) / 8) * 8;

    localparam logic ActAdd  = 1'b0;
    localparam logic ActTick = 1'b1;

    localparam logic StFired  = 1'b0;
    localparam logic StReject = 1'b1;

    typedef logic [TimeW-1:0] time_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture the incoming request
        logic insert;   // shift and insert the captured event
        logic pop;      // shift the queue down by one slot
    } dotq_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;     // queue holds Capacity events
        logic is_tick;  // captured request is a tick
        logic head_due; // head slot is valid and due
        logic next_due; // slot one is valid and due
    } dotq_stat_t;

endpackage

// File: hw/rtl/deadline_ordered_timer_queue.sv
// ----------------------------------------------------------------------------
// deadline_ordered_timer_queue: sorted queue of timed events
// Stores events by deadline and fires those due on each tick request.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes add and tick requests; m_ channel gives results.
//   s_tuser holds the action (0 = add, 1 = tick).
//   An add is captured, then shift-inserted into the
//   sorted slots. A full queue gives one reject result with m_tlast set.
//   A tick is captured, then due events leave the head slot one a cycle while
//   the receiver takes them, in deadline order, the final one with m_tlast.
//   A tick with nothing due gives no result.
//   Results pass through a single output register; while the receiver
//   stalls, firing or a reject pauses and no new request is taken meanwhile.
//   Reset empties the queue and the output register at once.
//   m_tuser holds status (1 = add rejected, queue full).
// ----------------------------------------------------------------------------
module deadline_ordered_timer_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_ms, delay_ms, listener_id, event_token (from bit 0)
    input  logic [dotq_pkg::InDW-1:0] s_tdata,
    // action
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // fired_listener, fired_token, fired_deadline (from bit 0)
    output logic [dotq_pkg::OutDW-1:0] m_tdata,
    // status
    output logic        m_tuser,
    output logic        m_tlast
);
    import dotq_pkg::*;

    dotq_cmd_t       cmd;
    dotq_stat_t      stat;
    logic [OutW-1:0] head_res, rej_res;
    logic            out_load, out_sel_rej, out_last, out_free;
    logic [OutW-1:0] res_reg;
    logic            last_reg, valid_reg;

    dotq_datapath u_dp (
        .aclk, .aresetn, .req_data(s_tdata), .req_kind(s_tuser), .cmd, .stat,
        .head_res, .rej_res
    );

    dotq_ctrl u_ctrl (
        .aclk, .aresetn, .s_fire(s_tvalid && s_tready), .s_ready(s_tready),
        .stat, .cmd, .out_load, .out_sel_rej, .out_last, .out_free
    );

    assign out_free = !valid_reg || m_tready;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            res_reg  <= out_sel_rej ? rej_res : head_res;
            last_reg <= out_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg[0];
    assign m_tdata  = OutDW'(res_reg[OutW-1:1]);
    assign m_tlast  = last_reg;

    // a result is only loaded when the register can take it
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free) else $error("result register overrun");
    // never insert and pop together
    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.insert && cmd.pop)) else $error("insert and pop together");
    // a reject is always marked last
    a_rej_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_sel_rej) |-> out_last) else $error("reject not last");

endmodule

// File: hw/rtl/dotq_datapath.sv
// ----------------------------------------------------------------------------
// dotq_datapath: sorted slot array with shift insert and head pop
// Holds the request register, the sorted slots and the due compares.
// ----------------------------------------------------------------------------
module dotq_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [dotq_pkg::InDW-1:0] req_data,
    input  logic                req_kind,
    input  dotq_pkg::dotq_cmd_t cmd,
    output dotq_pkg::dotq_stat_t stat,
    output logic [dotq_pkg::OutW-1:0] head_res,
    output logic [dotq_pkg::OutW-1:0] rej_res
);
    import dotq_pkg::*;

    logic                act_reg;
    time_t               now_reg;
    time_t               dl_reg;
    logic [LisW-1:0]     lis_reg;
    logic [TokW-1:0]     tok_reg;

    time_t               dl_mem_reg  [Capacity];
    logic [LisW-1:0]     lis_mem_reg [Capacity];
    logic [TokW-1:0]     tok_mem_reg [Capacity];
    logic [Capacity-1:0] valid_reg;

    logic [TimeW:0]      sum;
    time_t               dl_sat;
    logic [Capacity-1:0] after;

    // deadline with saturation
    assign sum    = {1'b0, req_data[TimeW-1:0]}
                  + (TimeW+1)'(req_data[TimeW+DelayW-1:TimeW]);
    assign dl_sat = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= req_kind;
            now_reg <= req_data[TimeW-1:0];
            dl_reg  <= dl_sat;
            lis_reg <= req_data[TimeW+DelayW+LisW-1:TimeW+DelayW];
            tok_reg <= req_data[InW-1:TimeW+DelayW+LisW];
        end
    end

    // slots whose deadline lies later than the new one
    always_comb begin
        for (int i = 0; i < Capacity; i++) begin
            after[i] = valid_reg[i] && (dl_mem_reg[i] > dl_reg);
        end
    end

    // slot array
    always_ff @(posedge aclk) begin
        for (int i = 0; i < Capacity; i++) begin
            if (cmd.insert) begin
                if (after[i]) begin
                    if (i > 0 && after[i-1]) begin
                        dl_mem_reg[i]  <= dl_mem_reg[i-1];
                        lis_mem_reg[i] <= lis_mem_reg[i-1];
                        tok_mem_reg[i] <= tok_mem_reg[i-1];
                    end else begin
                        dl_mem_reg[i]  <= dl_reg;
                        lis_mem_reg[i] <= lis_reg;
                        tok_mem_reg[i] <= tok_reg;
                    end
                end else if (i > 0 && !valid_reg[i] && after[i-1]) begin
                    dl_mem_reg[i]  <= dl_mem_reg[i-1];
                    lis_mem_reg[i] <= lis_mem_reg[i-1];
                    tok_mem_reg[i] <= tok_mem_reg[i-1];
                end else if (!valid_reg[i] && (i == 0 || valid_reg[i-1])) begin
                    dl_mem_reg[i]  <= dl_reg;
                    lis_mem_reg[i] <= lis_reg;
                    tok_mem_reg[i] <= tok_reg;
                end
            end else if (cmd.pop && i < Capacity - 1) begin
                dl_mem_reg[i]  <= dl_mem_reg[i+1];
                lis_mem_reg[i] <= lis_mem_reg[i+1];
                tok_mem_reg[i] <= tok_mem_reg[i+1];
            end
        end
    end

    // occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.insert) begin
            valid_reg <= {valid_reg[Capacity-2:0], 1'b1};
        end else if (cmd.pop) begin
            valid_reg <= {1'b0, valid_reg[Capacity-1:1]};
        end
    end

    assign stat.full     = valid_reg[Capacity-1];
    assign stat.is_tick  = act_reg == ActTick;
    assign stat.head_due = valid_reg[0] && (dl_mem_reg[0] <= now_reg);
    assign stat.next_due = valid_reg[1] && (dl_mem_reg[1] <= now_reg);

    assign head_res = {dl_mem_reg[0], tok_mem_reg[0], lis_mem_reg[0], StFired};
    assign rej_res  = {dl_reg, tok_reg, lis_reg, StReject};

endmodule

// File: hw/rtl/dotq_ctrl.sv
// ----------------------------------------------------------------------------
// dotq_ctrl: request sequencer for the timer queue
// Accepts a request, then inserts, rejects or fires due events one a cycle while the output register is free.
// ----------------------------------------------------------------------------
module dotq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_fire,
    output logic                 s_ready,
    input  dotq_pkg::dotq_stat_t stat,
    output dotq_pkg::dotq_cmd_t  cmd,
    output logic                 out_load,
    output logic                 out_sel_rej,
    output logic                 out_last,
    input  logic                 out_free
);
    import dotq_pkg::*;

    localparam logic [1:0] SIdle = 2'd0;
    localparam logic [1:0] SDec  = 2'd1;
    localparam logic [1:0] SFire = 2'd2;

    logic [1:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SIdle;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencing
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        out_load    = 1'b0;
        out_sel_rej = 1'b0;
        out_last    = 1'b0;
        unique case (state_reg)
            SIdle: begin
                s_ready = 1'b1;
                if (s_fire) begin
                    cmd.load   = 1'b1;
                    state_next = SDec;
                end
            end
            SDec: begin
                if (stat.is_tick) begin
                    state_next = stat.head_due ? SFire : SIdle;
                end else if (!stat.full) begin
                    cmd.insert = 1'b1;
                    state_next = SIdle;
                end else if (out_free) begin
                    out_load    = 1'b1;
                    out_sel_rej = 1'b1;
                    out_last    = 1'b1;
                    state_next  = SIdle;
                end
            end
            SFire: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_last   = !stat.next_due;
                    cmd.pop    = 1'b1;
                    state_next = stat.next_due ? SFire : SIdle;
                end
            end
            default: state_next = SIdle;
        endcase
    end

endmodule

// File: tb/deadline_ordered_timer_queue_test.sv
// ----------------------------------------------------------------------------
// deadline_ordered_timer_queue_test: self-checking bench for the timer queue
// Drives add and tick requests, predicts fired and rejected events from a
// sorted copy of the queue and checks every result in order.
// ----------------------------------------------------------------------------
module deadline_ordered_timer_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dotq_pkg::*;

    localparam int WatchLimit = 3000;
    localparam int DrainWait  = 40;

    // request kinds in the pending list
    typedef enum logic [1:0] {KReq, KDrain, KLongStall} kind_e;

    typedef struct {
        kind_e       kind;
        logic        action;
        time_t       now_ms;
        logic [31:0] delay_ms;
        logic [7:0]  listener;
        logic [31:0] token;
        int          idle_mode;
    } request_t;

    typedef struct {
        logic        status;
        logic [7:0]  listener;
        logic [31:0] token;
        time_t       deadline;
        logic        last;
    } event_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [InDW-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OutDW-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    request_t requests[$];
    event_t   expected_events[$];
    event_t   timer_slots[$];
    request_t cur_req;
    int       errors = 0;
    int       idle_mode = 0;
    int       drain_wait = 0;
    int       stall_cycles = 0;
    int       quiet_cycles = 0;
    bit       stall_request = 0;
    time_t    clock_ms;

    deadline_ordered_timer_queue u_top (.*);

    always #5 aclk = ~aclk;

    // predictor: sorted insert on add, due events leave on tick
    task automatic predict(input request_t r);
        event_t e;
        logic [48:0] sum;
        int pos;
        int n;
        if (r.action == ActAdd) begin
            sum = {1'b0, r.now_ms} + r.delay_ms;
            e.status = StFired;
            e.listener = r.listener;
            e.token = r.token;
            e.deadline = sum[48] ? '1 : sum[47:0];
            e.last = 1'b0;
            if (timer_slots.size() >= Capacity) begin
                e.status = StReject;
                e.last = 1'b1;
                expected_events.insert(expected_events.size(), e);
            end else begin
                pos = 0;
                while (pos < timer_slots.size()
                       && timer_slots[pos].deadline <= e.deadline)
                    pos++;
                timer_slots.insert(pos, e);
            end
        end else begin
            n = 0;
            while (n < timer_slots.size() && timer_slots[n].deadline <= r.now_ms)
                n++;
            for (int i = 0; i < n; i++) begin
                e = timer_slots.pop_front();
                e.last = (i == n - 1);
                expected_events.insert(expected_events.size(), e);
            end
        end
    endtask

    function automatic bit idle_roll(input int mode, input bit rx);
        if (mode == 3) return $urandom_range(99) < 11;
        if (mode == (rx ? 2 : 1)) return $urandom_range(99) < 73;
        return 0;
    endfunction

    // sender: one request at a time from the pending list
    always @(posedge aclk) begin
        logic v;
        v = s_tvalid;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict(cur_req);
                v = 1'b0;
            end
            if (!v) begin
                if (drain_wait > 0) begin
                    drain_wait--;
                end else if (requests.size() > 0) begin
                    if (requests[0].kind == KDrain) begin
                        if (expected_events.size() == 0) begin
                            void'(requests.pop_front());
                            drain_wait = DrainWait;
                        end
                    end else if (requests[0].kind == KLongStall) begin
                        void'(requests.pop_front());
                        stall_request = 1;
                    end else if (!idle_roll(requests[0].idle_mode, 0)) begin
                        cur_req = requests.pop_front();
                        idle_mode = cur_req.idle_mode;
                        s_tdata <= {cur_req.token, cur_req.listener, cur_req.delay_ms,
                                    cur_req.now_ms};
                        s_tuser <= cur_req.action;
                        v = 1'b1;
                    end
                end
            end
        end
        s_tvalid <= v;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (stall_request) begin
                stall_request = 0;
                stall_cycles = 300;
            end
            if (stall_cycles > 0) begin
                stall_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !idle_roll(idle_mode, 1);
            end
        end
    end

    // result check against the oldest expected event
    always @(posedge aclk) begin
        event_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_events.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: tdata %h user %b last %b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                e = expected_events.pop_front();
                if (m_tuser !== e.status || m_tdata[7:0] !== e.listener
                    || m_tdata[39:8] !== e.token || m_tdata[87:40] !== e.deadline
                    || m_tlast !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp st %b lis %h tok %h dl %h last %b",
                                  " / got st %b lis %h tok %h dl %h last %b"},
                                 e.status, e.listener, e.token, e.deadline, e.last,
                                 m_tuser, m_tdata[7:0], m_tdata[39:8], m_tdata[87:40],
                                 m_tlast);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchLimit) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_req(input kind_e k, input logic act, input time_t now,
                           input logic [31:0] dly, input logic [7:0] lis,
                           input logic [31:0] tok, input int mode);
        request_t r;
        r.kind = k;
        r.action = act;
        r.now_ms = now;
        r.delay_ms = dly;
        r.listener = lis;
        r.token = tok;
        r.idle_mode = mode;
        requests.insert(requests.size(), r);
    endtask

    task automatic random_phase(input int count, input int mode);
        time_t now;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 4) begin
                // far-future time with the top bit set, so most queued events fall due
                add_req(KReq, ActTick, {$urandom, $urandom} | 48'h8000_0000_0000, 0,
                        $urandom, $urandom, mode);
            end else if ($urandom_range(99) < 60) begin
                now = ($urandom_range(99) < 5) ? {$urandom, $urandom} : clock_ms;
                add_req(KReq, ActAdd, now,
                        ($urandom_range(9) == 0) ? $urandom : $urandom_range(80),
                        $urandom, $urandom, mode);
            end else begin
                clock_ms += $urandom_range(40);
                add_req(KReq, ActTick, clock_ms, $urandom, $urandom, $urandom, mode);
            end
        end
        add_req(KDrain, 0, 0, 0, 0, 0, mode);
    endtask

    initial begin
        clock_ms = 48'd1000;
        // directed: empty tick, extremes, saturation, equal deadlines, full queue
        add_req(KReq, ActTick, 0, 0, 0, 0, 0);
        add_req(KReq, ActAdd, 0, 0, 8'h00, 32'h0, 0);
        add_req(KReq, ActAdd, '1, '1, 8'hff, '1, 0);
        add_req(KReq, ActAdd, 48'd5, 32'd5, 8'h11, 32'h1, 0);
        add_req(KReq, ActAdd, 48'd8, 32'd2, 8'h22, 32'h2, 0);
        add_req(KReq, ActTick, 48'd10, 0, 0, 0, 0);
        add_req(KReq, ActTick, '1, 0, 0, 0, 0);
        for (int i = 0; i < 17; i++)
            add_req(KReq, ActAdd, 48'd20, 32'(16 - i), 8'(i), 32'(i), 0);
        add_req(KReq, ActTick, '1, 0, 0, 0, 0);
        add_req(KDrain, 0, 0, 0, 0, 0, 0);

        // long receiver hold-off while adds fill the queue and ticks back up
        add_req(KLongStall, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 20; i++)
            add_req(KReq, ActAdd, clock_ms, $urandom_range(5), $urandom, $urandom, 0);
        add_req(KReq, ActTick, clock_ms + 10, 0, 0, 0, 0);
        add_req(KReq, ActAdd, clock_ms, 0, $urandom, $urandom, 0);
        add_req(KReq, ActTick, '1, 0, 0, 0, 0);
        add_req(KDrain, 0, 0, 0, 0, 0, 0);

        random_phase(50, 0);
        random_phase(45, 1);
        random_phase(45, 2);
        random_phase(30, 3);
        random_phase(30, 0);
        add_req(KReq, ActTick, '1, 0, 0, 0, 0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (requests.size() != 0 || s_tvalid || expected_events.size() != 0)
            @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);
        if (errors == 0 && expected_events.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
